// ===== rtl/core/nmea_ubx_frame_splitter_unit_defines.svh =====
// ---------------------------------------------------------------------------
// NMEA/UBX frame splitter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NMEA_UBX_FRAME_SPLITTER_UNIT_DEFINES_SVH
`define NMEA_UBX_FRAME_SPLITTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NUFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nufs same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NUFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nufs next-cycle check failed");

`endif

// ===== rtl/core/nufs_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA/UBX frame splitter package
// Byte codes, frame kinds, event codes and the result item type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nufs_pkg;

  localparam int BUF_BYTES_DEF = 256;
  localparam int UBX_OVERHEAD  = 8;

  localparam logic [7:0] SYNC1      = 8'hB5;
  localparam logic [7:0] SYNC2      = 8'h62;
  localparam logic [7:0] NMEA_START = 8'h24;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NMEA = 2'd1;
  localparam logic [1:0] KIND_UBX  = 2'd2;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_NMEA_DONE = 3'd1;
  localparam logic [2:0] EV_UBX_DONE  = 3'd2;
  localparam logic [2:0] EV_OVERFLOW  = 3'd3;
  localparam logic [2:0] EV_BAD_SYNC  = 3'd4;
  localparam logic [2:0] EV_LEN_LARGE = 3'd5;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       stored;
    logic [7:0] position;
    logic [1:0] frame_kind;
    logic [2:0] event_res;
    logic [8:0] frame_length;
  } result_t;

endpackage

// ===== rtl/core/nmea_ubx_frame_splitter_unit.sv =====
// ---------------------------------------------------------------------------
// NMEA/UBX frame splitter
// Classifies each received byte as part of an NMEA line, a UBX frame or neither.
// ---------------------------------------------------------------------------
// Each byte passes through the input register and then the result register;
// a stalled result holds the byte behind it.
// Throughput: one byte per cycle while the result is not stalled; the parser
// state updates as a byte moves from the input register to the result register.
// Reset (rst, synchronous) empties both registers and returns the parser
// to waiting for a start byte with a zero fill count.
`timescale 1ns / 1ps
`include "nmea_ubx_frame_splitter_unit_defines.svh"

module nmea_ubx_frame_splitter_unit
  import nufs_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] byte_out,
  output logic       stored,
  output logic [7:0] position,
  output logic [1:0] frame_kind,
  output logic [2:0] event_res,
  output logic [8:0] frame_length
);

  localparam int FW = $clog2(BUF_BYTES + 1);

  localparam logic [FW-1:0] NMEA_LIMIT = FW'(BUF_BYTES - 1);
  localparam logic [FW-1:0] UBX_LIMIT  = FW'(BUF_BYTES);
  localparam logic [FW-1:0] LEN_DONE   = FW'(6);
  localparam logic [FW:0]   OVERHEAD   = (FW + 1)'(UBX_OVERHEAD);
  localparam logic [15:0]   LEN_MAX    = 16'(BUF_BYTES - UBX_OVERHEAD);

  localparam logic [2:0] S_WAIT    = 3'd0;
  localparam logic [2:0] S_NMEA    = 3'd1;
  localparam logic [2:0] S_SYNC2   = 3'd2;
  localparam logic [2:0] S_CLASS   = 3'd3;
  localparam logic [2:0] S_ID      = 3'd4;
  localparam logic [2:0] S_LEN     = 3'd5;
  localparam logic [2:0] S_PAYLOAD = 3'd6;

  // Input register and result register.
  logic          in_full;
  logic [7:0]    in_byte;
  logic          out_full;
  result_t       res;

  // Parser state.
  logic [2:0]    frame_state, frame_state_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic [7:0]    length_low, length_low_next;
  logic [FW-1:0] payload_length, payload_length_next;

  logic          out_ready;
  logic          advance;
  result_t       res_next;
  logic [FW-1:0] fill_inc;
  logic [15:0]   ubx_len;
  logic [FW+8:0] pos_wide;
  logic [FW+8:0] len_wide;
  logic [FW-1:0] pos_fill;
  logic [FW-1:0] len_fill;

  assign out_ready = !out_full || !res_stall;
  assign advance   = in_full && out_ready;
  assign rx_stall  = in_full && !out_ready;

  assign fill_inc  = fill_count + FW'(1);
  assign ubx_len   = {in_byte, length_low};

  always_comb begin
    frame_state_next    = frame_state;
    fill_count_next     = fill_count;
    length_low_next     = length_low;
    payload_length_next = payload_length;
    res_next            = '0;
    res_next.byte_out   = in_byte;
    pos_fill            = '0;
    len_fill            = '0;

    case (frame_state)
      S_WAIT: begin
        if (in_byte == NMEA_START || in_byte == SYNC1) begin
          res_next.stored = 1'b1;
          fill_count_next = FW'(1);
          if (in_byte == NMEA_START) begin
            res_next.frame_kind = KIND_NMEA;
            frame_state_next    = S_NMEA;
          end else begin
            res_next.frame_kind = KIND_UBX;
            frame_state_next    = S_SYNC2;
          end
        end
      end
      S_NMEA: begin
        res_next.frame_kind = KIND_NMEA;
        if (in_byte == CH_LF) begin
          res_next.event_res = EV_NMEA_DONE;
          len_fill           = fill_count;
          frame_state_next   = S_WAIT;
          fill_count_next    = '0;
        end else if (in_byte == CH_CR) begin
          // Carriage returns inside a line are dropped silently.
        end else if (fill_count < NMEA_LIMIT) begin
          res_next.stored = 1'b1;
          pos_fill        = fill_count;
          fill_count_next = fill_inc;
        end else begin
          res_next.event_res = EV_OVERFLOW;
          frame_state_next   = S_WAIT;
          fill_count_next    = '0;
        end
      end
      S_SYNC2: begin
        res_next.frame_kind = KIND_UBX;
        if (in_byte == SYNC2) begin
          res_next.stored  = 1'b1;
          pos_fill         = fill_count;
          fill_count_next  = fill_inc;
          frame_state_next = S_CLASS;
        end else begin
          res_next.event_res = EV_BAD_SYNC;
          frame_state_next   = S_WAIT;
          fill_count_next    = '0;
        end
      end
      S_CLASS, S_ID: begin
        res_next.frame_kind = KIND_UBX;
        res_next.stored     = 1'b1;
        pos_fill            = fill_count;
        fill_count_next     = fill_inc;
        frame_state_next    = frame_state + 3'd1;
      end
      S_LEN: begin
        res_next.frame_kind = KIND_UBX;
        res_next.stored     = 1'b1;
        pos_fill            = fill_count;
        fill_count_next     = fill_inc;
        if (fill_inc < LEN_DONE) begin
          length_low_next = in_byte;
        end else if (ubx_len > LEN_MAX) begin
          // The second length byte is still reported as stored.
          res_next.event_res = EV_LEN_LARGE;
          frame_state_next   = S_WAIT;
          fill_count_next    = '0;
        end else begin
          payload_length_next = ubx_len[FW-1:0];
          frame_state_next    = S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        res_next.frame_kind = KIND_UBX;
        if (fill_count < UBX_LIMIT) begin
          res_next.stored = 1'b1;
          pos_fill        = fill_count;
          fill_count_next = fill_inc;
          if ({1'b0, fill_inc} >= OVERHEAD + {1'b0, payload_length}) begin
            res_next.event_res = EV_UBX_DONE;
            len_fill           = fill_inc;
            frame_state_next   = S_WAIT;
            fill_count_next    = '0;
          end
        end else begin
          res_next.event_res = EV_OVERFLOW;
          frame_state_next   = S_WAIT;
          fill_count_next    = '0;
        end
      end
      default: begin
        frame_state_next = S_WAIT;
        fill_count_next  = '0;
      end
    endcase

    pos_wide              = {9'd0, pos_fill};
    len_wide              = {9'd0, len_fill};
    res_next.position     = pos_wide[7:0];
    res_next.frame_length = len_wide[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      out_full       <= 1'b0;
      frame_state    <= S_WAIT;
      fill_count     <= '0;
      length_low     <= '0;
      payload_length <= '0;
    end else begin
      if (rx_valid && !rx_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full       <= 1'b1;
        frame_state    <= frame_state_next;
        fill_count     <= fill_count_next;
        length_low     <= length_low_next;
        payload_length <= payload_length_next;
      end else if (!res_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign res_valid    = out_full;
  assign byte_out     = res.byte_out;
  assign stored       = res.stored;
  assign position     = res.position;
  assign frame_kind   = res.frame_kind;
  assign event_res    = res.event_res;
  assign frame_length = res.frame_length;

  `NUFS_ASSERT_SAME(a_idle_empty, frame_state == S_WAIT, fill_count == '0)
  `NUFS_ASSERT_SAME(a_payload_header, frame_state == S_PAYLOAD, fill_count >= LEN_DONE)
  `NUFS_ASSERT_NEXT(a_event_ends_frame, advance && res_next.event_res != EV_NONE, frame_state == S_WAIT)
  `NUFS_ASSERT_SAME(a_full_out_blocks, in_full && out_full && res_stall, rx_stall)

endmodule
